// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker
// Clocked, reset-qualified property forms that report through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Antecedent implies consequent in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: rtl/amalt_pkg.sv
// ----------------------------------------------------------------------------
// amalt_pkg
// Constants, widths and the CORDIC angle table for the airmass converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package amalt_pkg;

    // default CORDIC depth
    localparam int CORDIC_STAGES = 16;
    // width of the CORDIC x, y and z datapath
    localparam int CW            = 34;
    // number of entries held in the angle table
    localparam int ANG_ENTRIES   = 24;
    // steps of the integer square root
    localparam int ISQRT_STEPS   = 32;
    // restoring division steps after the first compare
    localparam int DIV_STEPS     = 30;

    localparam logic [31:0] GAIN_Q30    = 32'h26DD3B6A;
    localparam logic [24:0] DEG2RAD_Q30 = 25'd18740330;
    localparam logic [29:0] RAD2DEG_Q16 = 30'd961263669;
    localparam logic [14:0] ALT_LIMIT   = 15'd23040;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [28:0] MASK29      = 29'h1FFF_FFFF;
    localparam logic [11:0] SCALE_RESET = 12'd750;

    // atan(2^-i) in Q30 radians
    function automatic logic [31:0] cordic_angle(input int unsigned idx);
        logic [31:0] ang;
        case (idx)
            0:       ang = 32'h3243F6A8;
            1:       ang = 32'h1DAC6705;
            2:       ang = 32'h0FADBAFC;
            3:       ang = 32'h07F56EA6;
            4:       ang = 32'h03FEAB76;
            5:       ang = 32'h01FFD55B;
            6:       ang = 32'h00FFFAAA;
            7:       ang = 32'h007FFF55;
            8:       ang = 32'h003FFFEA;
            9:       ang = 32'h001FFFFD;
            10:      ang = 32'h000FFFFF;
            11:      ang = 32'h0007FFFF;
            12:      ang = 32'h0003FFFF;
            13:      ang = 32'h0001FFFF;
            14:      ang = 32'h0000FFFF;
            15:      ang = 32'h00007FFF;
            16:      ang = 32'h00003FFF;
            17:      ang = 32'h00001FFF;
            18:      ang = 32'h00000FFF;
            19:      ang = 32'h000007FF;
            20:      ang = 32'h000003FF;
            21:      ang = 32'h000001FF;
            22:      ang = 32'h000000FF;
            23:      ang = 32'h0000007F;
            default: ang = 32'h00000000;
        endcase
        return ang;
    endfunction

endpackage

`default_nettype wire

// File: rtl/amalt_cordic.sv
// ----------------------------------------------------------------------------
// amalt_cordic
// Pipelined CORDIC, one micro-rotation per register stage, in rotation or
// vectoring mode, with a side tag that travels with each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amalt_cordic #(
    parameter int STAGES    = amalt_pkg::CORDIC_STAGES,
    parameter bit VECTORING = 1'b0,
    parameter int TAG_W     = 1
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [amalt_pkg::CW-1:0]   x_in,
    input  wire logic signed [amalt_pkg::CW-1:0]   y_in,
    input  wire logic signed [amalt_pkg::CW-1:0]   z_in,
    input  wire logic        [TAG_W-1:0]           tag_in,
    output logic signed      [amalt_pkg::CW-1:0]   y_out,
    output logic signed      [amalt_pkg::CW-1:0]   z_out,
    output logic             [TAG_W-1:0]           tag_out
);

    localparam int CW = amalt_pkg::CW;

    logic signed [CW-1:0]    x_reg   [STAGES];
    logic signed [CW-1:0]    y_reg   [STAGES];
    logic signed [CW-1:0]    z_reg   [STAGES];
    logic        [TAG_W-1:0] tag_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [CW-1:0]    xp;
        logic signed [CW-1:0]    yp;
        logic signed [CW-1:0]    zp;
        logic        [TAG_W-1:0] tp;
        logic signed [CW-1:0]    dx;
        logic signed [CW-1:0]    dy;
        logic signed [CW-1:0]    ang;
        logic                    ccw;

        if (i == 0)
        begin : g_first
            assign xp = x_in;
            assign yp = y_in;
            assign zp = z_in;
            assign tp = tag_in;
        end
        else
        begin : g_next
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
            assign tp = tag_reg[i-1];
        end

        // shifted terms and direction of this micro-rotation
        always_comb
        begin
            dx  = yp >>> i;
            dy  = xp >>> i;
            ang = $signed({{(CW-32){1'b0}}, amalt_pkg::cordic_angle(i)});
            ccw = VECTORING ? yp[CW-1] : !zp[CW-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]   <= ccw ? xp - dx  : xp + dx;
                y_reg[i]   <= ccw ? yp + dy  : yp - dy;
                z_reg[i]   <= ccw ? zp - ang : zp + ang;
                tag_reg[i] <= tp;
            end
        end
    end

    assign y_out   = y_reg[STAGES-1];
    assign z_out   = z_reg[STAGES-1];
    assign tag_out = tag_reg[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/amalt_isqrt.sv
// ----------------------------------------------------------------------------
// amalt_isqrt
// Pipelined 64-bit integer square root, one result bit per register stage,
// with a side tag that travels with each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amalt_isqrt #(
    parameter int TAG_W = 1
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [63:0]      v_in,
    input  wire logic [TAG_W-1:0] tag_in,
    output logic      [31:0]      root_out,
    output logic      [TAG_W-1:0] tag_out
);

    localparam int STEPS = amalt_pkg::ISQRT_STEPS;

    logic [63:0]      v_reg   [STEPS];
    logic [63:0]      r_reg   [STEPS];
    logic [TAG_W-1:0] tag_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [63:0] BIT_K = 64'd1 << (62 - 2 * k);

        logic [63:0]      vp;
        logic [63:0]      rp;
        logic [TAG_W-1:0] tp;
        logic [63:0]      trial;

        if (k == 0)
        begin : g_first
            assign vp = v_in;
            assign rp = 64'd0;
            assign tp = tag_in;
        end
        else
        begin : g_next
            assign vp = v_reg[k-1];
            assign rp = r_reg[k-1];
            assign tp = tag_reg[k-1];
        end

        assign trial = rp + BIT_K;

        // trial subtract decides this result bit
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (vp >= trial)
                begin
                    v_reg[k] <= vp - trial;
                    r_reg[k] <= (rp >> 1) + BIT_K;
                end
                else
                begin
                    v_reg[k] <= vp;
                    r_reg[k] <= rp >> 1;
                end
                tag_reg[k] <= tp;
            end
        end
    end

    assign root_out = r_reg[STEPS-1][31:0];
    assign tag_out  = tag_reg[STEPS-1];

endmodule

`default_nettype wire

// File: rtl/airmass_altitude_conversion_top.sv
// ----------------------------------------------------------------------------
// airmass_altitude_conversion_top
// Airmass from altitude and altitude from airmass, spherical atmosphere.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle while item_stall is low. Two front stages,
// 31 division stages, one radicand stage, the 32-stage square root, the CORDIC
// stages and three output stages set the depth; the airmass path is padded to
// the same length. A two-entry output buffer lets the pipeline keep taking
// beats while a result waits; item_stall rises only once both entries are
// full. cfg_ready is always high and a scale write takes effect at once;
// write it only while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module airmass_altitude_conversion_top #(
    parameter int CORDIC_STAGES = amalt_pkg::CORDIC_STAGES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // item channel
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic               kind,
    input  wire logic signed [15:0] altitude_in,
    input  wire logic        [28:0] airmass_in,
    // result channel
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic             [28:0] airmass_out,
    output logic signed      [15:0] altitude_out,
    output logic                    out_of_range,
    // scale register write
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [11:0] cfg_data
);

    localparam int CW      = amalt_pkg::CW;
    localparam int DSTEPS  = amalt_pkg::DIV_STEPS + 1;
    localparam int LAT     = CORDIC_STAGES + 68;
    localparam int K0_PAD  = 32;

    localparam logic signed [16:0] ALT_HI   = $signed({2'b00, amalt_pkg::ALT_LIMIT});
    localparam logic signed [16:0] ALT_FOLD = $signed({1'b0, amalt_pkg::ALT_LIMIT, 1'b0});

    logic        en;
    logic        acc;
    logic [11:0] scale_reg;

    // ---------------- config and flow control ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= amalt_pkg::SCALE_RESET;
        else if (cfg_valid && cfg_ready)
            scale_reg <= cfg_data;
    end

    logic sk_full_reg;
    assign en         = !sk_full_reg;
    assign item_stall = sk_full_reg;
    assign acc        = item_valid && !item_stall;

    // valid bits travel alongside the datapath
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], acc};
    end

    // ================= airmass from altitude =================
    logic signed [16:0] alt_w;
    logic signed [16:0] alt_ref;
    logic signed [16:0] alt_abs;
    logic        [39:0] f_prod;
    logic        [31:0] f0_z_reg;
    logic               f0_neg_reg;

    // fold beyond the zenith, radians in Q30
    always_comb
    begin
        alt_w = {altitude_in[15], altitude_in};
        if (alt_w > ALT_HI)
            alt_ref = ALT_FOLD - alt_w;
        else if (alt_w < -ALT_HI)
            alt_ref = -ALT_FOLD - alt_w;
        else
            alt_ref = alt_w;
        alt_abs = alt_ref[16] ? -alt_ref : alt_ref;
        f_prod  = {25'd0, alt_abs[14:0]} * {15'd0, amalt_pkg::DEG2RAD_Q30} + 40'd128;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_z_reg   <= f_prod[39:8];
            f0_neg_reg <= alt_ref[16];
        end
    end

    logic signed [CW-1:0] sin_y;
    logic                 sin_neg;

    amalt_cordic #(
        .STAGES    (CORDIC_STAGES),
        .VECTORING (1'b0),
        .TAG_W     (1)
    ) u_sin (
        .clk     (clk),
        .en      (en),
        .x_in    ($signed({{(CW-32){1'b0}}, amalt_pkg::GAIN_Q30})),
        .y_in    ($signed({CW{1'b0}})),
        .z_in    ($signed({{(CW-32){1'b0}}, f0_z_reg})),
        .tag_in  (f0_neg_reg),
        .y_out   (sin_y),
        .z_out   (),
        .tag_out (sin_neg)
    );

    // clamp the sine, a = s * sin in Q16
    logic [30:0] yc;
    logic [43:0] a_sum;
    logic [27:0] a_aq_reg;
    logic        a_neg_reg;

    always_comb
    begin
        if (sin_y[CW-1])
            yc = '0;
        else if (sin_y > $signed({{(CW-31){1'b0}}, amalt_pkg::ONE_Q30}))
            yc = amalt_pkg::ONE_Q30;
        else
            yc = sin_y[30:0];
        a_sum = {32'd0, scale_reg} * {13'd0, yc} + 44'd8192;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_aq_reg  <= a_sum[41:14];
            a_neg_reg <= sin_neg;
        end
    end

    // radicand a^2 + (2s+1) * 2^32
    logic [55:0] b_sq;
    logic [63:0] b_v_reg;
    logic [27:0] b_aq_reg;
    logic        b_neg_reg;

    assign b_sq = {28'd0, a_aq_reg} * {28'd0, a_aq_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_v_reg   <= {8'd0, b_sq} + {19'd0, scale_reg, 1'b1, 32'd0};
            b_aq_reg  <= a_aq_reg;
            b_neg_reg <= a_neg_reg;
        end
    end

    logic [31:0] root0;
    logic [28:0] root0_tag;

    amalt_isqrt #(
        .TAG_W (29)
    ) u_root_am (
        .clk      (clk),
        .en       (en),
        .v_in     (b_v_reg),
        .tag_in   ({b_neg_reg, b_aq_reg}),
        .root_out (root0),
        .tag_out  (root0_tag)
    );

    // airmass = root -+ a, floored at zero and saturated
    logic [32:0] c_sum;
    logic [28:0] c_am_reg;
    logic [28:0] pad_reg [K0_PAD];

    always_comb
    begin
        if (root0_tag[28])
            c_sum = {1'b0, root0} + {5'd0, root0_tag[27:0]};
        else if (root0 >= {4'd0, root0_tag[27:0]})
            c_sum = {1'b0, root0} - {5'd0, root0_tag[27:0]};
        else
            c_sum = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_am_reg <= (c_sum > {4'd0, amalt_pkg::MASK29}) ? amalt_pkg::MASK29
                                                            : c_sum[28:0];
        end
    end

    // delay line that lines the airmass up with the altitude path
    for (genvar j = 0; j < K0_PAD; j++)
    begin : g_pad
        always_ff @(posedge clk)
        begin
            if (en)
                pad_reg[j] <= (j == 0) ? c_am_reg : pad_reg[(j == 0) ? 0 : j - 1];
        end
    end

    // ================= altitude from airmass =================
    logic [57:0] s0_xx_reg;
    logic [40:0] s0_xs_reg;
    logic        s0_bad_reg;
    logic        s0_kind_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_xx_reg   <= {29'd0, airmass_in} * {29'd0, airmass_in};
            s0_xs_reg   <= {12'd0, airmass_in} * {29'd0, scale_reg};
            s0_bad_reg  <= (airmass_in == '0) || (scale_reg == '0);
            s0_kind_reg <= kind;
        end
    end

    // numerator magnitude, sign, denominator and range check
    logic [57:0] s1_c;
    logic        s1_negw;
    logic [57:0] s1_magw;
    logic [57:0] s1_denw;
    logic [57:0] s1_mag_reg;
    logic [57:0] s1_den_reg;
    logic        s1_oor_reg;
    logic        s1_neg_reg;
    logic        s1_kind_reg;

    always_comb
    begin
        s1_c    = {13'd0, scale_reg, 1'b1, 32'd0};
        s1_negw = s0_xx_reg > s1_c;
        s1_magw = s1_negw ? s0_xx_reg - s1_c : s1_c - s0_xx_reg;
        s1_denw = {s0_xs_reg, 17'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg  <= s1_magw;
            s1_den_reg  <= s1_denw;
            s1_oor_reg  <= s0_bad_reg || (s1_magw > s1_denw);
            s1_neg_reg  <= s1_negw;
            s1_kind_reg <= s0_kind_reg;
        end
    end

    // restoring division, one quotient bit per stage
    logic [59:0] dr_reg   [DSTEPS];
    logic [30:0] dq_reg   [DSTEPS];
    logic [57:0] dd_reg   [DSTEPS];
    logic [2:0]  dtag_reg [DSTEPS];

    for (genvar k = 0; k < DSTEPS; k++)
    begin : g_div
        logic [59:0] rp;
        logic [30:0] qp;
        logic [57:0] dp;
        logic [2:0]  tp;

        if (k == 0)
        begin : g_first
            assign rp = {2'd0, s1_mag_reg};
            assign qp = '0;
            assign dp = s1_den_reg;
            assign tp = {s1_kind_reg, s1_oor_reg, s1_neg_reg};
        end
        else
        begin : g_next
            assign rp = {dr_reg[k-1][58:0], 1'b0};
            assign qp = {dq_reg[k-1][29:0], 1'b0};
            assign dp = dd_reg[k-1];
            assign tp = dtag_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rp >= {2'd0, dp})
                begin
                    dr_reg[k] <= rp - {2'd0, dp};
                    dq_reg[k] <= qp | 31'd1;
                end
                else
                begin
                    dr_reg[k] <= rp;
                    dq_reg[k] <= qp;
                end
                dd_reg[k]   <= dp;
                dtag_reg[k] <= tp;
            end
        end
    end

    // cosine radicand 2^60 - t^2
    logic [30:0] t_q;
    logic [61:0] t_sq;
    logic [63:0] t_v_reg;
    logic [33:0] t_tag_reg;

    assign t_q  = dq_reg[DSTEPS-1];
    assign t_sq = {31'd0, t_q} * {31'd0, t_q};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_v_reg   <= (64'd1 << 60) - {2'd0, t_sq};
            t_tag_reg <= {dtag_reg[DSTEPS-1], t_q};
        end
    end

    logic [31:0] cos_c;
    logic [33:0] cos_tag;

    amalt_isqrt #(
        .TAG_W (34)
    ) u_root_cos (
        .clk      (clk),
        .en       (en),
        .v_in     (t_v_reg),
        .tag_in   (t_tag_reg),
        .root_out (cos_c),
        .tag_out  (cos_tag)
    );

    logic signed [CW-1:0] asin_z;
    logic        [2:0]    asin_tag;

    amalt_cordic #(
        .STAGES    (CORDIC_STAGES),
        .VECTORING (1'b1),
        .TAG_W     (3)
    ) u_atan (
        .clk     (clk),
        .en      (en),
        .x_in    ($signed({{(CW-32){1'b0}}, cos_c})),
        .y_in    ($signed({{(CW-31){1'b0}}, cos_tag[30:0]})),
        .z_in    ($signed({CW{1'b0}})),
        .tag_in  (cos_tag[33:31]),
        .y_out   (),
        .z_out   (asin_z),
        .tag_out (asin_tag)
    );

    // radians to 1/256 degree
    logic [30:0] zc;
    logic [61:0] p_sum;
    logic [15:0] p1_deg_reg;
    logic [2:0]  p1_tag_reg;

    always_comb
    begin
        zc    = asin_z[CW-1] ? '0 : asin_z[30:0];
        p_sum = {31'd0, zc} * {32'd0, amalt_pkg::RAD2DEG_Q16} + (62'd1 << 45);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_deg_reg <= p_sum[61:46];
            p1_tag_reg <= asin_tag;
        end
    end

    // clamp, sign and out-of-range zeroing
    logic [15:0]        p2_degw;
    logic signed [15:0] p2_alt_reg;
    logic               p2_oor_reg;
    logic               p2_kind_reg;

    assign p2_degw = (p1_deg_reg > {1'b0, amalt_pkg::ALT_LIMIT}) ? {1'b0, amalt_pkg::ALT_LIMIT}
                                                                : p1_deg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (p1_tag_reg[1])
                p2_alt_reg <= '0;
            else if (p1_tag_reg[0])
                p2_alt_reg <= -$signed(p2_degw);
            else
                p2_alt_reg <= $signed(p2_degw);
            p2_oor_reg  <= p1_tag_reg[1];
            p2_kind_reg <= p1_tag_reg[2];
        end
    end

    // ================= result select and output buffer =================
    logic               p_valid;
    logic        [28:0] p_airmass;
    logic signed [15:0] p_alt;
    logic               p_oor;
    logic               out_ready;

    logic        [28:0] sk_airmass_reg;
    logic signed [15:0] sk_alt_reg;
    logic               sk_oor_reg;
    logic               out_valid_reg;
    logic        [28:0] out_airmass_reg;
    logic signed [15:0] out_alt_reg;
    logic               out_oor_reg;

    always_comb
    begin
        p_valid   = vld_reg[LAT-1];
        p_airmass = p2_kind_reg ? '0 : pad_reg[K0_PAD-1];
        p_alt     = p2_kind_reg ? p2_alt_reg : '0;
        p_oor     = p2_kind_reg && p2_oor_reg;
        out_ready = !out_valid_reg || !result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_full_reg   <= 1'b0;
        end
        else if (out_ready)
        begin
            if (sk_full_reg)
            begin
                out_valid_reg <= 1'b1;
                sk_full_reg   <= 1'b0;
            end
            else
            begin
                out_valid_reg <= p_valid;
            end
        end
        else if (p_valid)
        begin
            sk_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            if (sk_full_reg)
            begin
                out_airmass_reg <= sk_airmass_reg;
                out_alt_reg     <= sk_alt_reg;
                out_oor_reg     <= sk_oor_reg;
            end
            else
            begin
                out_airmass_reg <= p_airmass;
                out_alt_reg     <= p_alt;
                out_oor_reg     <= p_oor;
            end
        end
        else if (en && p_valid)
        begin
            sk_airmass_reg <= p_airmass;
            sk_alt_reg     <= p_alt;
            sk_oor_reg     <= p_oor;
        end
    end

    assign result_valid = out_valid_reg;
    assign airmass_out  = out_airmass_reg;
    assign altitude_out = out_alt_reg;
    assign out_of_range = out_oor_reg;

endmodule

`default_nettype wire

// File: rtl/amalt_checker.sv
// ----------------------------------------------------------------------------
// amalt_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module amalt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire logic        [28:0] airmass_out,
    input wire logic signed [15:0] altitude_out,
    input wire logic               out_of_range
);

    // a held result beat stays offered
    `CHK_NEXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid)
    // out of range reports a zero altitude
    `CHK_SAME(a_oor_alt, clk, rst_n, result_valid && out_of_range, altitude_out == 16'sd0)
    // out of range only comes from the altitude path
    `CHK_SAME(a_oor_am, clk, rst_n, result_valid && out_of_range, airmass_out == 29'd0)
    // altitude stays within the zenith limit
    `CHK_SAME(a_alt_lim, clk, rst_n, result_valid,
              altitude_out <= 16'sd23040 && altitude_out >= -16'sd23040)

endmodule

bind airmass_altitude_conversion_top amalt_checker u_amalt_checker (.*);

`default_nettype wire
